[rtl/biquad_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// biquad_pkg
// Shared constants, word types and control structs of the cascaded biquad
// filter: fixed-point widths, operation and coefficient codes, phase codes.
// ============================================================================
package biquad_pkg;

    localparam int MAX_SECTIONS   = 16;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;

    localparam int NCOEF          = 5;
    localparam int COEF_BITS      = 32;
    localparam int DELAY_BITS     = 32;
    localparam int ACTIVE_BITS    = 5;
    localparam int SEC_BITS       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int COEF_DEPTH     = MAX_SECTIONS * NCOEF;
    localparam int COEF_ADDR_BITS = $clog2(COEF_DEPTH);
    localparam int PROD_BITS      = COEF_BITS + DELAY_BITS;
    localparam int RND_BITS       = PROD_BITS - COEF_FRAC_BITS;
    localparam int ACC_BITS       = RND_BITS + 2;

    // operation codes
    localparam logic [1:0] OP_FILTER     = 2'd0;
    localparam logic [1:0] OP_WRITE_COEF = 2'd1;
    localparam logic [1:0] OP_CLEAR      = 2'd2;

    // coefficient select codes
    localparam logic [2:0] SEL_A1 = 3'd0;
    localparam logic [2:0] SEL_A2 = 3'd1;
    localparam logic [2:0] SEL_B0 = 3'd2;
    localparam logic [2:0] SEL_B1 = 3'd3;
    localparam logic [2:0] SEL_B2 = 3'd4;

    // per-section phases; each PH_MUL_* phase names the product formed in that cycle
    localparam logic [2:0] PH_FETCH  = 3'd0;
    localparam logic [2:0] PH_MUL_A1 = 3'd1;
    localparam logic [2:0] PH_MUL_A2 = 3'd2;
    localparam logic [2:0] PH_MUL_B1 = 3'd3;
    localparam logic [2:0] PH_MUL_B2 = 3'd4;
    localparam logic [2:0] PH_MUL_B0 = 3'd5;
    localparam logic [2:0] PH_SUM_B0 = 3'd6;
    localparam logic [2:0] PH_SAT_Y  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } biquad_state_t;

    typedef struct packed {
        logic [1:0]                    operation;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [3:0]                    section_index;
        logic [2:0]                    coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
    } biquad_req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } biquad_rsp_t;

    typedef struct packed {
        logic       start;
        logic       run;
        logic [2:0] phase;
        logic       coef_ok;
        logic       delay_ok;
    } biquad_ctl_t;

    typedef struct packed {
        logic                      coef_we;
        logic [COEF_ADDR_BITS-1:0] coef_waddr;
        logic [COEF_ADDR_BITS-1:0] coef_raddr;
        logic                      delay_we;
        logic [SEC_BITS-1:0]       delay_addr;
    } biquad_mem_t;

endpackage

[rtl/biquad_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// biquad_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module biquad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/biquad_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// biquad_datapath
// Shared multiply-accumulate for the biquad sections: one registered 32x32
// product per cycle, rounding, accumulation and saturation of w and y.
// ============================================================================
module biquad_datapath import biquad_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  biquad_ctl_t                 ctl,
    input  biquad_req_t                 req_data,
    input  logic [COEF_BITS-1:0]        coef_rdata,
    input  logic [2*DELAY_BITS-1:0]     delay_rdata,
    output logic [2*DELAY_BITS-1:0]     delay_wdata,
    output biquad_rsp_t                 rsp
);

    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [DELAY_BITS-1:0] DELAY_MAX =
        {1'b0, {(DELAY_BITS-1){1'b1}}};
    localparam logic signed [DELAY_BITS-1:0] DELAY_MIN =
        {1'b1, {(DELAY_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [DELAY_BITS-1:0] x_reg, x_next;
    logic signed [DELAY_BITS-1:0] w_reg, w_next;
    logic signed [DELAY_BITS-1:0] w1_reg, w1_next;
    logic signed [DELAY_BITS-1:0] w2_reg, w2_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                         sat_reg, sat_next;

    logic signed [COEF_BITS-1:0]  mul_a;
    logic signed [DELAY_BITS-1:0] mul_b;
    logic signed [DELAY_BITS-1:0] rd_w1;
    logic signed [DELAY_BITS-1:0] rd_w2;
    logic signed [PROD_BITS-1:0]  prod_rnd;
    logic signed [RND_BITS-1:0]   rnd;
    logic                         acc_ovf;
    logic signed [DELAY_BITS-1:0] acc_sat;
    logic                         out_ovf;

    // unwritten entries read as zero
    assign mul_a = ctl.coef_ok  ? coef_rdata : '0;
    assign rd_w1 = ctl.delay_ok ? delay_rdata[2*DELAY_BITS-1:DELAY_BITS] : '0;
    assign rd_w2 = ctl.delay_ok ? delay_rdata[DELAY_BITS-1:0] : '0;

    assign prod_rnd = prod_reg + ROUND_HALF;
    assign rnd      = prod_rnd[PROD_BITS-1:COEF_FRAC_BITS];

    assign acc_ovf = !((&acc_reg[ACC_BITS-1:DELAY_BITS-1]) ||
                       (~|acc_reg[ACC_BITS-1:DELAY_BITS-1]));
    assign acc_sat = acc_ovf ? (acc_reg[ACC_BITS-1] ? DELAY_MIN : DELAY_MAX)
                             : acc_reg[DELAY_BITS-1:0];

    always_comb
    begin
        unique case (ctl.phase)
            PH_MUL_A1: mul_b = rd_w1;
            PH_MUL_A2: mul_b = w2_reg;
            PH_MUL_B1: mul_b = w1_reg;
            PH_MUL_B2: mul_b = w2_reg;
            PH_MUL_B0: mul_b = w_reg;
            default:   mul_b = '0;
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        w_next    = w_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        prod_next = mul_a * mul_b;
        if (ctl.start)
        begin
            x_next   = DELAY_BITS'(req_data.sample_in);
            sat_next = 1'b0;
        end
        else if (ctl.run)
        begin
            unique case (ctl.phase)
                PH_FETCH:
                begin
                end
                PH_MUL_A1:
                begin
                    w1_next = rd_w1;
                    w2_next = rd_w2;
                end
                PH_MUL_A2:
                begin
                    acc_next = ACC_BITS'(x_reg) + ACC_BITS'(rnd);
                end
                PH_MUL_B1:
                begin
                    acc_next = acc_reg + ACC_BITS'(rnd);
                end
                PH_MUL_B2:
                begin
                    // close w, start the y sum with b1*w1
                    w_next   = acc_sat;
                    sat_next = sat_reg | acc_ovf;
                    acc_next = ACC_BITS'(rnd);
                end
                PH_MUL_B0:
                begin
                    acc_next = acc_reg + ACC_BITS'(rnd);
                end
                PH_SUM_B0:
                begin
                    acc_next = acc_reg + ACC_BITS'(rnd);
                end
                PH_SAT_Y:
                begin
                    x_next   = acc_sat;
                    sat_next = sat_reg | acc_ovf;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        w_reg    <= w_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // delay_one takes w, delay_two takes the old w1
    assign delay_wdata = {w_reg, w1_reg};

    assign out_ovf = !((&x_reg[DELAY_BITS-1:SAMPLE_BITS-1]) ||
                       (~|x_reg[DELAY_BITS-1:SAMPLE_BITS-1]));

    always_comb
    begin
        rsp.sample_out = out_ovf ? (x_reg[DELAY_BITS-1] ? OUT_MIN : OUT_MAX)
                                 : x_reg[SAMPLE_BITS-1:0];
        rsp.saturated  = sat_reg | out_ovf;
    end

endmodule

[rtl/biquad_seq.sv]
`timescale 1ns / 1ps
// ============================================================================
// biquad_seq
// Item sequencer: accepts words, walks sections and phases, drives the
// coefficient and delay memories and keeps their written-entry bits.
// ============================================================================
module biquad_seq import biquad_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  biquad_req_t            req_data,
    output logic                   req_ready,
    input  logic                   cfg_we,
    input  logic [ACTIVE_BITS-1:0] cfg_wdata,
    input  logic                   out_free,
    output logic                   emit,
    output logic                   emit_filter,
    output biquad_ctl_t            ctl,
    output biquad_mem_t            mem
);

    biquad_state_t state_reg, state_next;
    logic [2:0]             phase_reg, phase_next;
    logic [SEC_BITS-1:0]    sec_reg, sec_next;
    logic [ACTIVE_BITS-1:0] active_reg;
    logic [COEF_DEPTH-1:0]  coef_valid_reg, coef_valid_next;
    logic [MAX_SECTIONS-1:0] delay_valid_reg, delay_valid_next;
    logic                   coef_ok_reg;
    logic                   delay_ok_reg;

    logic                   accept;
    logic                   is_filter;
    logic                   last_phase;
    logic                   last_sec_hit;
    logic [SEC_BITS-1:0]    last_sec;
    logic [2:0]             rd_sel;

    assign accept     = req_valid && req_ready;
    assign is_filter  = (req_data.operation == OP_FILTER);
    assign last_phase = (phase_reg == PH_SAT_Y);

    // zero sections run as one, too many run as the maximum
    always_comb
    begin
        priority if (active_reg == '0)
        begin
            last_sec = '0;
        end
        else if (32'(active_reg) > MAX_SECTIONS)
        begin
            last_sec = SEC_BITS'(MAX_SECTIONS - 1);
        end
        else
        begin
            last_sec = SEC_BITS'(32'(active_reg) - 32'd1);
        end
    end

    assign last_sec_hit = (sec_reg == last_sec);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_filter)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_phase && last_sec_hit)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // coefficient fetch order: a1, a2, b1, b2, b0
    always_comb
    begin
        unique case (phase_reg)
            PH_FETCH:  rd_sel = SEL_A1;
            PH_MUL_A1: rd_sel = SEL_A2;
            PH_MUL_A2: rd_sel = SEL_B1;
            PH_MUL_B1: rd_sel = SEL_B2;
            default:   rd_sel = SEL_B0;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        emit        = 1'b0;
        emit_filter = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = out_free;
                emit      = accept && !is_filter;
            end
            ST_RUN:
            begin
            end
            ST_DONE:
            begin
                emit        = out_free;
                emit_filter = 1'b1;
            end
            default:
            begin
            end
        endcase

        ctl.start    = (state_reg == ST_IDLE) && accept && is_filter;
        ctl.run      = (state_reg == ST_RUN);
        ctl.phase    = phase_reg;
        ctl.coef_ok  = coef_ok_reg;
        ctl.delay_ok = delay_ok_reg;

        mem.coef_we    = accept && (req_data.operation == OP_WRITE_COEF) &&
                         (32'(req_data.section_index) < MAX_SECTIONS) &&
                         (32'(req_data.coef_select) < NCOEF);
        mem.coef_waddr = COEF_ADDR_BITS'(32'(req_data.section_index) * NCOEF +
                                         32'(req_data.coef_select));
        mem.coef_raddr = COEF_ADDR_BITS'(32'(sec_reg) * NCOEF + 32'(rd_sel));
        mem.delay_we   = (state_reg == ST_RUN) && (phase_reg == PH_MUL_B0);
        mem.delay_addr = sec_reg;
    end

    // counters and written-entry bits
    always_comb
    begin
        phase_next       = phase_reg;
        sec_next         = sec_reg;
        coef_valid_next  = coef_valid_reg;
        delay_valid_next = delay_valid_reg;
        if (ctl.start)
        begin
            phase_next = PH_FETCH;
            sec_next   = '0;
        end
        else if (ctl.run)
        begin
            phase_next = phase_reg + 3'd1;
            if (last_phase)
            begin
                sec_next = last_sec_hit ? '0 : sec_reg + 1'b1;
            end
        end
        if (mem.coef_we)
        begin
            coef_valid_next[mem.coef_waddr] = 1'b1;
        end
        if (accept && (req_data.operation == OP_CLEAR))
        begin
            delay_valid_next = '0;
        end
        if (mem.delay_we)
        begin
            delay_valid_next[sec_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_FETCH;
            sec_reg         <= '0;
            active_reg      <= ACTIVE_BITS'(1);
            coef_valid_reg  <= '0;
            delay_valid_reg <= '0;
            coef_ok_reg     <= 1'b0;
            delay_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            sec_reg         <= sec_next;
            coef_valid_reg  <= coef_valid_next;
            delay_valid_reg <= delay_valid_next;
            // track the RAM read latency
            coef_ok_reg     <= coef_valid_reg[mem.coef_raddr];
            delay_ok_reg    <= delay_valid_reg[sec_reg];
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

endmodule

[rtl/cascaded_biquad_iir_filter.sv]
`timescale 1ns / 1ps
// ============================================================================
// cascaded_biquad_iir_filter
// Cascade of up to MAX_SECTIONS direct-form-II biquad sections in fixed point.
// ============================================================================
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one word per item:
//   filter a sample, write one coefficient, or clear all delays. Every item
//   returns exactly one rsp word (rsp_valid/rsp_ready/rsp_data); non-sample
//   items return zero.
//   cfg_we/cfg_wdata set the number of active sections; write only when idle.
//   Coefficients sit in an 80-entry RAM, delays in a 16-entry RAM; one
//   shared 32x32 multiplier with registered product serves all taps.
//   Flow: per active section a sample passes a fetch phase, five multiply
//   phases (one coefficient RAM read per product), a last rounding sum and a
//   saturation phase, then waits in its done state for the hand-off to the
//   rsp register; no new item is taken before that hand-off. Non-sample items
//   respond next cycle and can follow back to back.
//   Reset: sections = 1, all coefficients and delays read as zero (written-
//   entry bits are cleared at once, no sweep). rsp_valid drops.
//   A stalled receiver holds the rsp word and req_ready stays low until it is
//   taken; a finished sample waits in its done state for the output register.
// ============================================================================
module cascaded_biquad_iir_filter import biquad_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  biquad_req_t            req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output biquad_rsp_t            rsp_data,
    input  logic                   cfg_we,
    input  logic [ACTIVE_BITS-1:0] cfg_wdata
);

    biquad_ctl_t              ctl;
    biquad_mem_t              mem;
    logic                     emit;
    logic                     emit_filter;
    logic                     out_free;
    logic [COEF_BITS-1:0]     coef_rdata;
    logic [2*DELAY_BITS-1:0]  delay_rdata;
    logic [2*DELAY_BITS-1:0]  delay_wdata;
    biquad_rsp_t              dp_rsp;

    logic                     rsp_valid_reg, rsp_valid_next;
    biquad_rsp_t              rsp_data_reg, rsp_data_next;

    assign out_free = !rsp_valid_reg || rsp_ready;

    biquad_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_data    (req_data),
        .req_ready   (req_ready),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_free    (out_free),
        .emit        (emit),
        .emit_filter (emit_filter),
        .ctl         (ctl),
        .mem         (mem)
    );

    biquad_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (mem.coef_we),
        .waddr (mem.coef_waddr),
        .wdata (req_data.coef_value),
        .raddr (mem.coef_raddr),
        .rdata (coef_rdata)
    );

    biquad_ram #(
        .WIDTH (2 * DELAY_BITS),
        .DEPTH (MAX_SECTIONS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (mem.delay_we),
        .waddr (mem.delay_addr),
        .wdata (delay_wdata),
        .raddr (mem.delay_addr),
        .rdata (delay_rdata)
    );

    biquad_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .req_data    (req_data),
        .coef_rdata  (coef_rdata),
        .delay_rdata (delay_rdata),
        .delay_wdata (delay_wdata),
        .rsp         (dp_rsp)
    );

    // output register: load on emit, drop when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = emit_filter ? dp_rsp : '0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // a non-sample word answers on the next cycle
    a_quick_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_data.operation != OP_FILTER)) |=> rsp_valid)
        else $error("non-sample word gave no response");

    // delay write-back only while a sample is in flight
    a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem.delay_we |-> !req_ready)
        else $error("delay write while accepting words");

    // coefficient writes only with an accepted word
    a_coef_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem.coef_we |-> (req_valid && req_ready && !ctl.run))
        else $error("coefficient write outside an accepted word");

endmodule

[test/cascaded_biquad_iir_filter_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// cascaded_biquad_iir_filter_tb
// Drives sample, coefficient-write, clear and unused-code words into the biquad cascade
// with random idle bursts on both channels. A bit-exact fixed-point model in
// a scoreboard class predicts every response word, which is then checked
// in order. The section count is swept through its legal and clamped values.
// ============================================================================
module cascaded_biquad_iir_filter_tb import biquad_pkg::*;;

    localparam int ITEM_TARGET    = 800;
    localparam int QUIET_AFTER    = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8 * MAX_SECTIONS + 20;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 32'h7FFF_FFFF;
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 32'h8000_0000;
    localparam logic signed [COEF_BITS-1:0]   COEF_UNITY = 32'(1) << COEF_FRAC_BITS;

    class biquad_scoreboard;
        longint      delay_one [MAX_SECTIONS];
        longint      delay_two [MAX_SECTIONS];
        longint      coef_bank [COEF_DEPTH];
        int          sections = 1;
        bit          clipped;
        biquad_rsp_t pending_outputs [$];
        int          mismatches;
        int          checked;
        int          samples;
        int          clipped_samples;
        int          coef_writes;
        int          clears;
        int          ignored;

        function void set_sections(logic [ACTIVE_BITS-1:0] v);
            sections = v;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // coefficient times delay, rounded half up
        function longint round_mul(longint c, longint v);
            return (c * v + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi)
            begin
                clipped = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                clipped = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function biquad_rsp_t run_cascade(longint x);
            biquad_rsp_t r;
            int          n;
            int          base;
            longint      w1;
            longint      w2;
            longint      w;
            longint      wide_max;
            longint      wide_min;
            longint      out_max;
            wide_max = 64'sd2147483647;
            wide_min = -wide_max - 1;
            out_max  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            n = sections;
            if (n < 1)
                n = 1;
            if (n > MAX_SECTIONS)
                n = MAX_SECTIONS;
            clipped = 1'b0;
            for (int k = 0; k < n; k++)
            begin
                base = k * NCOEF;
                w1 = delay_one[k];
                w2 = delay_two[k];
                w = x + round_mul(coef_bank[base + SEL_A1], w1)
                      + round_mul(coef_bank[base + SEL_A2], w2);
                w = clip(w, wide_min, wide_max);
                x = round_mul(coef_bank[base + SEL_B0], w)
                  + round_mul(coef_bank[base + SEL_B1], w1)
                  + round_mul(coef_bank[base + SEL_B2], w2);
                x = clip(x, wide_min, wide_max);
                delay_two[k] = w1;
                delay_one[k] = w;
            end
            x = clip(x, -out_max - 1, out_max);
            r.sample_out = x[SAMPLE_BITS-1:0];
            r.saturated  = clipped;
            return r;
        endfunction

        function void note_word(biquad_req_t w);
            biquad_rsp_t r;
            r = '0;
            case (w.operation)
                OP_FILTER:
                begin
                    r = run_cascade($signed(w.sample_in));
                    samples++;
                    if (r.saturated)
                        clipped_samples++;
                end
                OP_WRITE_COEF:
                begin
                    if (w.coef_select < NCOEF && w.section_index < MAX_SECTIONS)
                    begin
                        coef_bank[w.section_index * NCOEF + w.coef_select] =
                            $signed(w.coef_value);
                        coef_writes++;
                    end
                    else
                        ignored++;
                end
                OP_CLEAR:
                begin
                    foreach (delay_one[k])
                    begin
                        delay_one[k] = 0;
                        delay_two[k] = 0;
                    end
                    clears++;
                end
                default: ignored++;
            endcase
            pending_outputs.push_back(r);
        endfunction

        function void check_word(biquad_rsp_t got);
            biquad_rsp_t want;
            checked++;
            if (pending_outputs.size() == 0)
            begin
                flag($sformatf("unexpected result sample_out=%0d saturated=%0b",
                               got.sample_out, got.saturated));
                return;
            end
            want = pending_outputs.pop_front();
            if (got.sample_out !== want.sample_out)
                flag($sformatf("result %0d sample_out expected %0d got %0d",
                               checked, want.sample_out, got.sample_out));
            if (got.saturated !== want.saturated)
                flag($sformatf("result %0d saturated expected %0b got %0b",
                               checked, want.saturated, got.saturated));
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    biquad_req_t            req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    biquad_rsp_t            rsp_data;
    logic                   cfg_we    = 1'b0;
    logic [ACTIVE_BITS-1:0] cfg_wdata = '0;

    biquad_scoreboard sb;
    bit               no_idle = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               settings_used = 0;

    cascaded_biquad_iir_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response side: random stall bursts
    always @(posedge clk)
    begin
        if (no_idle)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if ($urandom_range(5) == 0)
        begin
            stall_left <= $urandom_range(9);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_word(rsp_data);
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("** cascaded_biquad_iir_filter: FAILED **");
                    $finish;
                end
            end
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic biquad_req_t random_word();
        biquad_req_t w;
        w.operation     = 2'($urandom_range(3));
        w.sample_in     = SAMPLE_BITS'($urandom);
        w.section_index = 4'($urandom);
        w.coef_select   = 3'($urandom);
        w.coef_value    = $urandom;
        return w;
    endfunction

    task automatic send_word(input biquad_req_t w);
        if (!no_idle && $urandom_range(3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge clk);
        end
        req_data  <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_word(w);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        biquad_req_t w;
        w = random_word();
        w.operation = OP_FILTER;
        w.sample_in = s;
        send_word(w);
    endtask

    task automatic send_coef(input int sec, input logic [2:0] sel,
                             input logic [COEF_BITS-1:0] value);
        biquad_req_t w;
        w = random_word();
        w.operation     = OP_WRITE_COEF;
        w.section_index = 4'(sec);
        w.coef_select   = sel;
        w.coef_value    = value;
        send_word(w);
    endtask

    task automatic send_op(input logic [1:0] op);
        biquad_req_t w;
        w = random_word();
        w.operation = op;
        send_word(w);
    endtask

    // hold the sender until the cascade has drained, then write the count
    task automatic program_sections(input logic [ACTIVE_BITS-1:0] v);
        req_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_sections(v);
        settings_used++;
    endtask

    initial
    begin
        int                        phase;
        int                        v;
        int                        n;
        logic [COEF_BITS-1:0]      c;
        logic [SAMPLE_BITS-1:0]    s;
        sb = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero coefficients, extremes, ignored words, saturation paths
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_op(OP_UNUSED);
        send_coef(0, SEL_B0, COEF_UNITY);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        for (int sel = NCOEF; sel < 8; sel++)
            send_coef(0, 3'(sel), $urandom);
        send_coef(0, SEL_B0, COEF_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_coef(0, SEL_A1, COEF_MAX);
        repeat (3) send_sample(SAMPLE_MAX);
        send_op(OP_CLEAR);
        send_sample('0);
        send_coef(MAX_SECTIONS - 1, SEL_B2, COEF_MAX);
        send_coef(0, SEL_A2, COEF_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        phase = 0;
        while (sb.samples + sb.coef_writes + sb.clears < ITEM_TARGET)
        begin
            case (phase)
                0: v = 2;
                1: v = 0;
                2: v = 16;
                3: v = 31;
                4: v = 17;
                5: v = 3;
                6: v = 1;
                default:
                begin
                    if ($urandom_range(9) == 0)
                        v = $urandom_range(31);
                    else
                        v = $urandom_range(4, 1);
                end
            endcase
            no_idle = (sb.samples + sb.coef_writes + sb.clears >= QUIET_AFTER) ||
                      ($urandom_range(6) == 0);
            program_sections(ACTIVE_BITS'(v));
            n = (v == 0) ? 1 : ((v > MAX_SECTIONS) ? MAX_SECTIONS : v);

            if ($urandom_range(6) == 0)
            begin
                repeat (20) send_word(random_word());
            end
            else
            begin
                if ($urandom_range(1) == 0)
                    send_op(OP_CLEAR);
                // mostly stable sections, now and then a wild coefficient
                for (int k = 0; k < n; k++)
                begin
                    for (int sel = 0; sel < NCOEF; sel++)
                    begin
                        if ($urandom_range(7) == 0)
                            c = $urandom;
                        else if (sel == SEL_A1)
                            c = rand_between(-201326592, 201326592);
                        else if (sel == SEL_A2)
                            c = rand_between(-187904819, 53687091);
                        else
                            c = rand_between(-201326592, 201326592);
                        send_coef(k, 3'(sel), c);
                    end
                end
                repeat ((n > 8) ? $urandom_range(10, 5) : $urandom_range(40, 10))
                begin
                    if ($urandom_range(12) == 0)
                        send_word(random_word());
                    else
                    begin
                        case ($urandom_range(9))
                            0:       s = SAMPLE_MAX;
                            1:       s = SAMPLE_MIN;
                            2, 3:    s = SAMPLE_BITS'($urandom);
                            default: s = SAMPLE_BITS'(rand_between(-1048576, 1048576));
                        endcase
                        send_sample(s);
                    end
                end
            end
            phase++;
        end

        no_idle = 1'b1;
        req_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_outputs.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending_outputs.size()));

        $display("coverage: %0d samples (%0d saturated), %0d coefficient writes, %0d clears",
                 sb.samples, sb.clipped_samples, sb.coef_writes, sb.clears);
        $display("coverage: %0d ignored words, %0d section-count settings, %0d results checked",
                 sb.ignored, settings_used, sb.checked);
        if (sb.mismatches == 0)
            $display("** cascaded_biquad_iir_filter: PASSED **");
        else
        begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("** cascaded_biquad_iir_filter: FAILED **");
        end
        $finish;
    end

endmodule

[cascaded_biquad_iir_filter.f]
rtl/biquad_pkg.sv
rtl/biquad_ram.sv
rtl/biquad_datapath.sv
rtl/biquad_seq.sv
rtl/cascaded_biquad_iir_filter.sv
test/cascaded_biquad_iir_filter_tb.sv
